[rtl/ncc_pkg.sv]
`default_nettype none
package ncc_pkg;

  localparam int MAX_IMAGE_WIDTH     = 1024;
  localparam int MAX_TEMPLATE_WIDTH  = 32;
  localparam int MAX_TEMPLATE_HEIGHT = 32;
  localparam int PIXEL_BITS          = 16;

  localparam int PIX_PORT_W = 16;
  localparam int IW_W       = 11;
  localparam int IH_W       = 12;
  localparam int TW_W       = 6;
  localparam int TH_W       = 6;
  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 12;
  localparam int COEF_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPLATE_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMPLATE_HEIGHT = 2'd3;

  localparam int TSTORE_DEPTH = MAX_TEMPLATE_WIDTH * MAX_TEMPLATE_HEIGHT;
  localparam int LSTORE_DEPTH = MAX_IMAGE_WIDTH * MAX_TEMPLATE_HEIGHT;
  localparam int TA_W   = $clog2(TSTORE_DEPTH);
  localparam int LA_W   = $clog2(LSTORE_DEPTH);
  localparam int N_W    = $clog2(TSTORE_DEPTH + 1);
  localparam int SLOT_W = $clog2(MAX_TEMPLATE_HEIGHT);
  localparam int LCOL_W = $clog2(MAX_IMAGE_WIDTH);
  localparam int TC_W   = $clog2(MAX_TEMPLATE_WIDTH + 1);
  localparam int TR_W   = $clog2(MAX_TEMPLATE_HEIGHT + 1);

  localparam int ST_W   = PIXEL_BITS + TA_W;
  localparam int EN_W   = 2 * PIXEL_BITS + TA_W;
  localparam int WT_W   = ST_W + 1;
  localparam int PR_W   = WT_W + PIXEL_BITS + 1;
  localparam int NUM_W  = PR_W + TA_W;
  localparam int D_W    = N_W + EN_W;
  localparam int AB_W   = 2 * D_W;
  localparam int FRAC_W = COEF_W;
  localparam int Q_W    = 2 * FRAC_W + 1;
  localparam int RT_W   = FRAC_W + 1;

  typedef struct packed {
    logic                  en;
    logic [TA_W-1:0]       addr;
    logic [PIXEL_BITS-1:0] data;
  } tmpl_wr_t;

  typedef struct packed {
    logic                  en;
    logic [LA_W-1:0]       addr;
    logic [PIXEL_BITS-1:0] data;
  } line_wr_t;

  typedef struct packed {
    logic [LCOL_W-1:0] left;
    logic [SLOT_W-1:0] top_slot;
    logic [TC_W-1:0]   tw;
    logic [TR_W-1:0]   th;
    logic [N_W-1:0]    n;
    logic [ST_W-1:0]   st;
    logic [N_W-1:0]    count;
  } walk_cmd_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic [ST_W-1:0]         si;
    logic [EN_W-1:0]         si2;
  } walk_sum_t;

endpackage
`default_nettype wire

[rtl/ncc_walk.sv]
`default_nettype none
module ncc_walk (
  input  logic               clk,
  input  logic               rst,
  input  ncc_pkg::tmpl_wr_t  tmpl_wr,
  input  ncc_pkg::line_wr_t  line_wr,
  input  logic               start,
  input  ncc_pkg::walk_cmd_t cmd,
  output logic               done,
  output ncc_pkg::walk_sum_t sums
);

  logic [ncc_pkg::PIXEL_BITS-1:0] tmem [ncc_pkg::TSTORE_DEPTH];
  logic [ncc_pkg::PIXEL_BITS-1:0] lmem [ncc_pkg::LSTORE_DEPTH];
  logic [ncc_pkg::PIXEL_BITS-1:0] tq;
  logic [ncc_pkg::PIXEL_BITS-1:0] lq;

  ncc_pkg::walk_cmd_t cur;
  logic busy;
  logic [ncc_pkg::TR_W-1:0]   r;
  logic [ncc_pkg::TC_W-1:0]   c;
  logic [ncc_pkg::SLOT_W-1:0] slot;
  logic [ncc_pkg::N_W-1:0]    ti;
  logic [ncc_pkg::LCOL_W-1:0] lcol;
  logic [ncc_pkg::TA_W-1:0]   t_raddr;
  logic [ncc_pkg::LA_W-1:0]   l_raddr;
  logic last_issue;
  logic row_end;

  logic v1, l1, z1, v2, l2, v3, l3;
  logic [ncc_pkg::PIXEL_BITS-1:0] tv;
  logic [ncc_pkg::N_W+ncc_pkg::PIXEL_BITS-1:0] ntv;
  logic signed [ncc_pkg::WT_W-1:0] wt;
  logic [ncc_pkg::PIXEL_BITS-1:0] iv1, iv2;
  logic signed [ncc_pkg::PR_W-1:0] prod;
  logic [2*ncc_pkg::PIXEL_BITS-1:0] isq;

  assign t_raddr = ti[ncc_pkg::TA_W-1:0];
  assign l_raddr = ncc_pkg::LA_W'(slot) * ncc_pkg::LA_W'(ncc_pkg::MAX_IMAGE_WIDTH)
                 + ncc_pkg::LA_W'(lcol);
  assign row_end    = (c == cur.tw - 1'b1);
  assign last_issue = row_end && (r == cur.th - 1'b1);

  always_comb begin
    tv  = z1 ? tq : '0;
    ntv = cur.n * tv;
  end

  always_ff @(posedge clk) begin
    if (tmpl_wr.en) begin
      tmem[tmpl_wr.addr] <= tmpl_wr.data;
    end
    if (line_wr.en) begin
      lmem[line_wr.addr] <= line_wr.data;
    end
    tq <= tmem[t_raddr];
    lq <= lmem[l_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      l1   <= 1'b0;
      l2   <= 1'b0;
      l3   <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
      end else if (busy && last_issue) begin
        busy <= 1'b0;
      end
      v1   <= busy;
      l1   <= busy && last_issue;
      v2   <= v1;
      l2   <= l1;
      v3   <= v2;
      l3   <= l2;
      done <= v3 && l3;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cur  <= cmd;
      r    <= '0;
      c    <= '0;
      slot <= cmd.top_slot;
      ti   <= '0;
      lcol <= cmd.left;
    end else if (busy) begin
      if (row_end) begin
        c    <= '0;
        lcol <= cur.left;
        r    <= r + 1'b1;
        slot <= (slot == ncc_pkg::SLOT_W'(ncc_pkg::MAX_TEMPLATE_HEIGHT - 1)) ? '0 : slot + 1'b1;
      end else begin
        c    <= c + 1'b1;
        lcol <= lcol + 1'b1;
      end
      ti <= ti + 1'b1;
    end
    z1   <= ti < cur.count;
    wt   <= $signed({1'b0, ntv[ncc_pkg::ST_W-1:0]}) - $signed({1'b0, cur.st});
    iv1  <= lq;
    prod <= wt * $signed({1'b0, iv1});
    isq  <= iv1 * iv1;
    iv2  <= iv1;
    if (start) begin
      sums <= '0;
    end else if (v3) begin
      sums.num <= sums.num + prod;
      sums.si  <= sums.si + ncc_pkg::ST_W'(iv2);
      sums.si2 <= sums.si2 + ncc_pkg::EN_W'(isq);
    end
  end

endmodule
`default_nettype wire

[rtl/ncc_ratio.sv]
`default_nettype none
module ncc_ratio (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  ncc_pkg::walk_sum_t           sums,
  input  logic [ncc_pkg::N_W-1:0]      n,
  input  logic [ncc_pkg::ST_W-1:0]     st,
  input  logic [ncc_pkg::EN_W-1:0]     en,
  output logic                         done,
  output logic signed [ncc_pkg::COEF_W-1:0] coef
);

  localparam int H     = ncc_pkg::EN_W / 2;
  localparam int HI_W  = ncc_pkg::EN_W - H;
  localparam int CNT_W = $clog2(ncc_pkg::D_W);
  localparam int SR_W  = ncc_pkg::RT_W + 3;
  localparam int QMAX  = (1 << (ncc_pkg::COEF_W - 1)) - 1;

  localparam logic [3:0] R_IDLE  = 4'd0;
  localparam logic [3:0] R_PREP1 = 4'd1;
  localparam logic [3:0] R_PREP2 = 4'd2;
  localparam logic [3:0] R_PREP3 = 4'd3;
  localparam logic [3:0] R_CHECK = 4'd4;
  localparam logic [3:0] R_MUL1  = 4'd5;
  localparam logic [3:0] R_MUL2  = 4'd6;
  localparam logic [3:0] R_DIV   = 4'd7;
  localparam logic [3:0] R_SQRT  = 4'd8;
  localparam logic [3:0] R_OUT   = 4'd9;

  logic [3:0] state;
  logic [CNT_W-1:0] cnt;
  logic neg;
  logic [ncc_pkg::D_W-1:0] mag, mag_next;
  logic [ncc_pkg::N_W+H-1:0]    plo_i, plo_t;
  logic [ncc_pkg::N_W+HI_W-1:0] phi_i, phi_t;
  logic [2*ncc_pkg::ST_W-1:0]   sqi, sqt;
  logic [ncc_pkg::D_W-1:0] da, db;

  logic [ncc_pkg::D_W-1:0] ma, mhi, mlo;
  logic [ncc_pkg::D_W:0]   msum;
  logic [ncc_pkg::AB_W-1:0] mfin;
  logic [ncc_pkg::AB_W-1:0] num2, ab;

  logic [ncc_pkg::AB_W:0] rem, dsh, ddiff;
  logic dge;
  logic [ncc_pkg::Q_W-1:0] quot, qfin;

  logic [2*ncc_pkg::RT_W-1:0] rad;
  logic [SR_W-1:0] srem, scur, strial;
  logic sge;
  logic [ncc_pkg::RT_W-1:0] root, rfin, mid;
  logic [ncc_pkg::RT_W:0] rinc;
  logic [ncc_pkg::COEF_W-1:0] qsat;

  assign done = (state == R_OUT);

  always_comb begin
    mag_next = sums.num[ncc_pkg::NUM_W-1] ? ncc_pkg::D_W'(-sums.num)
                                          : ncc_pkg::D_W'(sums.num);
    msum  = {1'b0, mhi} + (mlo[0] ? {1'b0, ma} : '0);
    mfin  = {msum, mlo[ncc_pkg::D_W-1:1]};
    dsh   = (cnt == '0) ? rem : {rem[ncc_pkg::AB_W-1:0], 1'b0};
    dge   = dsh >= {1'b0, ab};
    ddiff = dsh - {1'b0, ab};
    qfin  = {quot[ncc_pkg::Q_W-2:0], dge};
    scur   = {srem[SR_W-3:0], rad[2*ncc_pkg::RT_W-1 -: 2]};
    strial = SR_W'({root, 2'b01});
    sge    = scur >= strial;
    rfin   = {root[ncc_pkg::RT_W-2:0], sge};
    rinc   = {1'b0, rfin} + 1'b1;
    mid    = rinc[ncc_pkg::RT_W:1];
    qsat   = (mid > ncc_pkg::RT_W'(QMAX)) ? ncc_pkg::COEF_W'(QMAX) : ncc_pkg::COEF_W'(mid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
    end else begin
      case (state)
        R_IDLE:  if (start) state <= R_PREP1;
        R_PREP1: state <= R_PREP2;
        R_PREP2: state <= R_PREP3;
        R_PREP3: state <= R_CHECK;
        R_CHECK: state <= (da == '0 || db == '0) ? R_OUT : R_MUL1;
        R_MUL1:  if (cnt == CNT_W'(ncc_pkg::D_W - 1)) state <= R_MUL2;
        R_MUL2:  if (cnt == CNT_W'(ncc_pkg::D_W - 1)) state <= R_DIV;
        R_DIV:   if (cnt == CNT_W'(ncc_pkg::Q_W - 1)) state <= R_SQRT;
        R_SQRT:  if (cnt == CNT_W'(ncc_pkg::RT_W - 1)) state <= R_OUT;
        R_OUT:   state <= R_IDLE;
        default: state <= R_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      R_PREP1: begin
        neg   <= sums.num[ncc_pkg::NUM_W-1];
        mag   <= mag_next;
        plo_i <= n * sums.si2[H-1:0];
        plo_t <= n * en[H-1:0];
      end
      R_PREP2: begin
        phi_i <= n * sums.si2[ncc_pkg::EN_W-1:H];
        phi_t <= n * en[ncc_pkg::EN_W-1:H];
        sqi   <= sums.si * sums.si;
        sqt   <= st * st;
      end
      R_PREP3: begin
        da <= ncc_pkg::D_W'({phi_i, {H{1'b0}}}) + ncc_pkg::D_W'(plo_i) - ncc_pkg::D_W'(sqi);
        db <= ncc_pkg::D_W'({phi_t, {H{1'b0}}}) + ncc_pkg::D_W'(plo_t) - ncc_pkg::D_W'(sqt);
      end
      R_CHECK: begin
        coef <= '0;
        ma   <= mag;
        mhi  <= '0;
        mlo  <= mag;
        cnt  <= '0;
      end
      R_MUL1: begin
        if (cnt == CNT_W'(ncc_pkg::D_W - 1)) begin
          num2 <= mfin;
          ma   <= da;
          mhi  <= '0;
          mlo  <= db;
          cnt  <= '0;
        end else begin
          mhi <= msum[ncc_pkg::D_W:1];
          mlo <= {msum[0], mlo[ncc_pkg::D_W-1:1]};
          cnt <= cnt + 1'b1;
        end
      end
      R_MUL2: begin
        if (cnt == CNT_W'(ncc_pkg::D_W - 1)) begin
          ab   <= mfin;
          rem  <= {1'b0, num2};
          quot <= '0;
          cnt  <= '0;
        end else begin
          mhi <= msum[ncc_pkg::D_W:1];
          mlo <= {msum[0], mlo[ncc_pkg::D_W-1:1]};
          cnt <= cnt + 1'b1;
        end
      end
      R_DIV: begin
        rem  <= dge ? ddiff : dsh;
        quot <= qfin;
        if (cnt == CNT_W'(ncc_pkg::Q_W - 1)) begin
          rad  <= (2*ncc_pkg::RT_W)'(qfin);
          srem <= '0;
          root <= '0;
          cnt  <= '0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      R_SQRT: begin
        srem <= sge ? scur - strial : scur;
        root <= rfin;
        rad  <= {rad[2*ncc_pkg::RT_W-3:0], 2'b00};
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(ncc_pkg::RT_W - 1)) begin
          coef <= neg ? -$signed(qsat) : $signed(qsat);
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/normalized_cross_correlation_unit.sv]
`default_nettype none
// Zero-mean normalized cross-correlation template matcher. Load the template
// (op 0) in raster order, then stream the image (op 1) in raster order; each
// pixel that closes a template-sized window yields one Q1.15 coefficient with
// the window's top-left position. Template pixels and image pixels that close
// no window leave the input ready. A closing pixel holds the input through
// the window walk through the line and template memories (one read each per
// cycle) and handoff, setup, two shift-add multiplies, a restoring divide, a
// square root and the load of the output. The result sits in an output
// register, so a stalled consumer holds the block only once a second result
// is ready. Memories need no clearing after reset.
module normalized_cross_correlation_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ncc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ncc_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              op,
  input  logic [ncc_pkg::PIX_PORT_W-1:0]    pixel_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ncc_pkg::COEF_W-1:0] coefficient,
  output logic [ncc_pkg::COL_W-1:0]         result_column,
  output logic [ncc_pkg::ROW_W-1:0]         result_row,
  output logic                              last_of_image
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_RATIO = 2'd2;
  localparam logic [1:0] S_HOLD  = 2'd3;

  logic [1:0] state;
  logic [ncc_pkg::IW_W-1:0] image_width;
  logic [ncc_pkg::IH_W-1:0] image_height;
  logic [ncc_pkg::TW_W-1:0] template_width;
  logic [ncc_pkg::TH_W-1:0] template_height;
  logic [ncc_pkg::IW_W-1:0] ew;
  logic [ncc_pkg::IH_W-1:0] eh;
  logic [ncc_pkg::TW_W-1:0] etw;
  logic [ncc_pkg::TH_W-1:0] eth;
  logic [ncc_pkg::TW_W+ncc_pkg::TH_W-1:0] nprod;
  logic [ncc_pkg::N_W-1:0] n;

  logic [ncc_pkg::ST_W-1:0] tsum, base_sum, st_l;
  logic [ncc_pkg::EN_W-1:0] tenergy, base_en, en_l;
  logic [ncc_pkg::N_W-1:0]  tcount, base_count, n_l;
  logic [ncc_pkg::COL_W-1:0]  col;
  logic [ncc_pkg::ROW_W-1:0]  row;
  logic [ncc_pkg::SLOT_W-1:0] row_slot;
  logic [ncc_pkg::PIXEL_BITS-1:0] px;
  logic [2*ncc_pkg::PIXEL_BITS-1:0] psq;

  logic acc;
  logic [ncc_pkg::COL_W:0] col_inc;
  logic [ncc_pkg::ROW_W:0] row_inc;
  logic complete, col_wrap, row_wrap, is_last;
  logic [ncc_pkg::SLOT_W+1:0] tsl;
  logic [ncc_pkg::SLOT_W-1:0] top_slot;
  logic [ncc_pkg::COL_W:0] left_w;
  logic [ncc_pkg::ROW_W:0] top_w;

  ncc_pkg::tmpl_wr_t  tmpl_wr;
  ncc_pkg::line_wr_t  line_wr;
  ncc_pkg::walk_cmd_t wcmd;
  ncc_pkg::walk_sum_t wsums;
  logic walk_start, walk_done, ratio_start, ratio_done, out_load;
  logic signed [ncc_pkg::COEF_W-1:0] ratio_coef;
  logic [ncc_pkg::COL_W-1:0] res_col;
  logic [ncc_pkg::ROW_W-1:0] res_row;
  logic res_last;

  always_comb begin
    if (image_width == '0) ew = ncc_pkg::IW_W'(1);
    else if (image_width > ncc_pkg::IW_W'(ncc_pkg::MAX_IMAGE_WIDTH))
      ew = ncc_pkg::IW_W'(ncc_pkg::MAX_IMAGE_WIDTH);
    else ew = image_width;
    eh = (image_height == '0) ? ncc_pkg::IH_W'(1) : image_height;
    if (template_width == '0) etw = ncc_pkg::TW_W'(1);
    else if (template_width > ncc_pkg::TW_W'(ncc_pkg::MAX_TEMPLATE_WIDTH))
      etw = ncc_pkg::TW_W'(ncc_pkg::MAX_TEMPLATE_WIDTH);
    else etw = template_width;
    if (ncc_pkg::IW_W'(etw) > ew) etw = ew[ncc_pkg::TW_W-1:0];
    if (template_height == '0) eth = ncc_pkg::TH_W'(1);
    else if (template_height > ncc_pkg::TH_W'(ncc_pkg::MAX_TEMPLATE_HEIGHT))
      eth = ncc_pkg::TH_W'(ncc_pkg::MAX_TEMPLATE_HEIGHT);
    else eth = template_height;
    if (ncc_pkg::IH_W'(eth) > eh) eth = eh[ncc_pkg::TH_W-1:0];
    nprod = etw * eth;
    n     = ncc_pkg::N_W'(nprod);
  end

  assign in_ready = (state == S_IDLE) && !rst;
  assign acc      = in_valid && in_ready;
  assign px       = pixel_value[ncc_pkg::PIXEL_BITS-1:0];

  always_comb begin
    psq        = px * px;
    base_count = (tcount >= n) ? '0 : tcount;
    base_sum   = (tcount >= n) ? '0 : tsum;
    base_en    = (tcount >= n) ? '0 : tenergy;
    col_inc    = {1'b0, col} + 1'b1;
    row_inc    = {1'b0, row} + 1'b1;
    col_wrap   = col_inc >= (ncc_pkg::COL_W+1)'(ew);
    row_wrap   = row_inc >= (ncc_pkg::ROW_W+1)'(eh);
    complete   = (col_inc >= (ncc_pkg::COL_W+1)'(etw)) &&
                 (row_inc >= (ncc_pkg::ROW_W+1)'(eth));
    is_last    = col_wrap && row_wrap;
    left_w     = col_inc - (ncc_pkg::COL_W+1)'(etw);
    top_w      = row_inc - (ncc_pkg::ROW_W+1)'(eth);
    tsl        = (ncc_pkg::SLOT_W+2)'(row_slot)
               + (ncc_pkg::SLOT_W+2)'(ncc_pkg::MAX_TEMPLATE_HEIGHT)
               - (ncc_pkg::SLOT_W+2)'(eth) + 1'b1;
    if (tsl >= (ncc_pkg::SLOT_W+2)'(ncc_pkg::MAX_TEMPLATE_HEIGHT))
      tsl = tsl - (ncc_pkg::SLOT_W+2)'(ncc_pkg::MAX_TEMPLATE_HEIGHT);
    top_slot   = tsl[ncc_pkg::SLOT_W-1:0];

    tmpl_wr.en   = acc && !op;
    tmpl_wr.addr = base_count[ncc_pkg::TA_W-1:0];
    tmpl_wr.data = px;
    line_wr.en   = acc && op;
    line_wr.addr = ncc_pkg::LA_W'(row_slot) * ncc_pkg::LA_W'(ncc_pkg::MAX_IMAGE_WIDTH)
                 + ncc_pkg::LA_W'(col);
    line_wr.data = px;
  end

  assign out_load = ((state == S_RATIO && ratio_done) || state == S_HOLD) &&
                    (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      image_width     <= ncc_pkg::IW_W'(64);
      image_height    <= ncc_pkg::IH_W'(64);
      template_width  <= ncc_pkg::TW_W'(8);
      template_height <= ncc_pkg::TH_W'(8);
      tsum            <= '0;
      tenergy         <= '0;
      tcount          <= '0;
      col             <= '0;
      row             <= '0;
      row_slot        <= '0;
      walk_start      <= 1'b0;
      ratio_start     <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      walk_start  <= 1'b0;
      ratio_start <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          ncc_pkg::CFG_IMAGE_WIDTH:     image_width     <= cfg_data[ncc_pkg::IW_W-1:0];
          ncc_pkg::CFG_IMAGE_HEIGHT:    image_height    <= cfg_data[ncc_pkg::IH_W-1:0];
          ncc_pkg::CFG_TEMPLATE_WIDTH:  template_width  <= cfg_data[ncc_pkg::TW_W-1:0];
          ncc_pkg::CFG_TEMPLATE_HEIGHT: template_height <= cfg_data[ncc_pkg::TH_W-1:0];
          default: begin
          end
        endcase
        tsum     <= '0;
        tenergy  <= '0;
        tcount   <= '0;
        col      <= '0;
        row      <= '0;
        row_slot <= '0;
      end else if (acc && !op) begin
        col      <= '0;
        row      <= '0;
        row_slot <= '0;
        tsum     <= base_sum + ncc_pkg::ST_W'(px);
        tenergy  <= base_en + ncc_pkg::EN_W'(psq);
        tcount   <= base_count + 1'b1;
      end else if (acc) begin
        if (complete) begin
          walk_start <= 1'b1;
          state      <= S_WALK;
        end
        if (col_wrap) begin
          col <= '0;
          if (row_wrap) begin
            row      <= '0;
            row_slot <= '0;
            tsum     <= '0;
            tenergy  <= '0;
            tcount   <= '0;
          end else begin
            row      <= row + 1'b1;
            row_slot <= (row_slot == ncc_pkg::SLOT_W'(ncc_pkg::MAX_TEMPLATE_HEIGHT - 1)) ?
                        '0 : row_slot + 1'b1;
          end
        end else begin
          col <= col + 1'b1;
        end
      end

      case (state)
        S_WALK: begin
          if (walk_done) begin
            ratio_start <= 1'b1;
            state       <= S_RATIO;
          end
        end
        S_RATIO: begin
          if (ratio_done) state <= out_load ? S_IDLE : S_HOLD;
        end
        S_HOLD: begin
          if (out_load) state <= S_IDLE;
        end
        default: begin
        end
      endcase

      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && op && complete) begin
      wcmd.left     <= left_w[ncc_pkg::LCOL_W-1:0];
      wcmd.top_slot <= top_slot;
      wcmd.tw       <= ncc_pkg::TC_W'(etw);
      wcmd.th       <= ncc_pkg::TR_W'(eth);
      wcmd.n        <= n;
      wcmd.st       <= tsum;
      wcmd.count    <= tcount;
      st_l          <= tsum;
      en_l          <= tenergy;
      n_l           <= n;
      res_col       <= left_w[ncc_pkg::COL_W-1:0];
      res_row       <= top_w[ncc_pkg::ROW_W-1:0];
      res_last      <= is_last;
    end
    if (out_load) begin
      coefficient   <= ratio_coef;
      result_column <= res_col;
      result_row    <= res_row;
      last_of_image <= res_last;
    end
  end

  ncc_walk u_walk (
    .clk     (clk),
    .rst     (rst),
    .tmpl_wr (tmpl_wr),
    .line_wr (line_wr),
    .start   (walk_start),
    .cmd     (wcmd),
    .done    (walk_done),
    .sums    (wsums)
  );

  ncc_ratio u_ratio (
    .clk   (clk),
    .rst   (rst),
    .start (ratio_start),
    .sums  (wsums),
    .n     (n_l),
    .st    (st_l),
    .en    (en_l),
    .done  (ratio_done),
    .coef  (ratio_coef)
  );

endmodule
`default_nettype wire

[rtl/ncc_checker.sv]
`default_nettype none
module ncc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              cfg_we,
  input logic [ncc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input logic [ncc_pkg::CFG_W-1:0]         cfg_data,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              op,
  input logic [ncc_pkg::PIX_PORT_W-1:0]    pixel_value,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [ncc_pkg::COEF_W-1:0] coefficient,
  input logic [ncc_pkg::COL_W-1:0]         result_column,
  input logic [ncc_pkg::ROW_W-1:0]         result_row,
  input logic                              last_of_image
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(coefficient) &&
      $stable(result_column) && $stable(result_row) && $stable(last_of_image))
    else $error("result changed while stalled");

  a_coef_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> coefficient != {1'b1, {(ncc_pkg::COEF_W-1){1'b0}}})
    else $error("coefficient below saturation limit");

  a_tmpl_one_cycle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !op |=> in_ready)
    else $error("template transfer stalled input");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result present after reset");

endmodule

bind normalized_cross_correlation_unit ncc_checker u_ncc_checker (.*);
`default_nettype wire

[dv/normalized_cross_correlation_unit_tb.sv]
`default_nettype none
module normalized_cross_correlation_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_TEMPLATE = 1'b0;
  localparam logic OP_IMAGE    = 1'b1;
  localparam int   DRAIN_CYCLES = 1300;
  localparam int   HOLD_CYCLES  = 3000;
  localparam int   HOLD_AT      = 30;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam int   RANDOM_ITEMS = 300;

  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    int unsigned sel;
    int unsigned value;
    bit          has_coef;
    int          coef;
  } stim_row_t;

  typedef struct {
    logic signed [ncc_pkg::COEF_W-1:0] coef;
    logic [ncc_pkg::COL_W-1:0]         col;
    logic [ncc_pkg::ROW_W-1:0]         row;
    logic                              last;
  } match_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_we = 1'b0;
  logic [ncc_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [ncc_pkg::CFG_W-1:0]         cfg_data = '0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic                              op = 1'b0;
  logic [ncc_pkg::PIX_PORT_W-1:0]    pixel_value = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic signed [ncc_pkg::COEF_W-1:0] coefficient;
  logic [ncc_pkg::COL_W-1:0]         result_column;
  logic [ncc_pkg::ROW_W-1:0]         result_row;
  logic                              last_of_image;

  normalized_cross_correlation_unit uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .pixel_value(pixel_value),
    .out_valid(out_valid), .out_ready(out_ready), .coefficient(coefficient),
    .result_column(result_column), .result_row(result_row),
    .last_of_image(last_of_image)
  );

  always #2 clk = ~clk;

  longint cycles = 0;
  int     errors = 0;
  int     matches_seen = 0;
  bit     quiet = 1'b0;
  match_t expected_matches[$];
  stim_row_t stim_table[$];

  logic [15:0]     tmpl_mem[ncc_pkg::TSTORE_DEPTH];
  logic [15:0]     line_mem[ncc_pkg::LSTORE_DEPTH];
  longint unsigned tmpl_sum, tmpl_energy;
  int unsigned     tmpl_count, col_pos, row_pos;
  int unsigned     img_w_reg, img_h_reg, tmpl_w_reg, tmpl_h_reg;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int draw_gap();
    if ($urandom_range(0, 40) == 0) quiet = ~quiet;
    if (quiet) return 0;
    return $urandom_range(0, 19);
  endfunction

  function automatic logic [15:0] draw_pixel();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 3));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic void clear_template();
    tmpl_count = 0;
    tmpl_sum = 0;
    tmpl_energy = 0;
  endfunction

  function automatic void apply_register(int unsigned idx, int unsigned value);
    case (idx)
      ncc_pkg::CFG_IMAGE_WIDTH:     img_w_reg = value & 32'h7FF;
      ncc_pkg::CFG_IMAGE_HEIGHT:    img_h_reg = value & 32'hFFF;
      ncc_pkg::CFG_TEMPLATE_WIDTH:  tmpl_w_reg = value & 32'h3F;
      ncc_pkg::CFG_TEMPLATE_HEIGHT: tmpl_h_reg = value & 32'h3F;
      default: return;
    endcase
    clear_template();
    col_pos = 0;
    row_pos = 0;
  endfunction

  function automatic int q15_coef(longint signed num, longint unsigned a, longint unsigned b);
    logic [199:0] ab, rhs, lhs, odd;
    longint unsigned mag;
    int unsigned lo, hi, mid;
    if (a == 0 || b == 0) return 0;
    mag = num < 0 ? -num : num;
    ab = 200'(a) * 200'(b);
    rhs = (200'(mag) * 200'(mag)) << 32;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      odd = 200'(2 * mid - 1);
      lhs = odd * odd * ab;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    if (lo > 32767) lo = 32767;
    return num < 0 ? -int'(lo) : int'(lo);
  endfunction

  task automatic predict_match(input logic opv, input logic [15:0] px,
                               output bit got, output match_t m);
    int unsigned w, h, tw, th, n, col, row, left, top, base, ti;
    longint signed num, st, tv;
    longint unsigned si, si2, da, db, iv;
    got = 1'b0;
    m = '{default: '0};
    w = img_w_reg < 1 ? 1 : (img_w_reg > ncc_pkg::MAX_IMAGE_WIDTH ?
                             ncc_pkg::MAX_IMAGE_WIDTH : img_w_reg);
    h = img_h_reg < 1 ? 1 : img_h_reg;
    tw = tmpl_w_reg < 1 ? 1 : (tmpl_w_reg > ncc_pkg::MAX_TEMPLATE_WIDTH ?
                               ncc_pkg::MAX_TEMPLATE_WIDTH : tmpl_w_reg);
    if (tw > w) tw = w;
    th = tmpl_h_reg < 1 ? 1 : (tmpl_h_reg > ncc_pkg::MAX_TEMPLATE_HEIGHT ?
                               ncc_pkg::MAX_TEMPLATE_HEIGHT : tmpl_h_reg);
    if (th > h) th = h;
    n = tw * th;
    if (opv == OP_TEMPLATE) begin
      col_pos = 0;
      row_pos = 0;
      if (tmpl_count >= n) clear_template();
      tmpl_mem[tmpl_count % ncc_pkg::TSTORE_DEPTH] = px;
      tmpl_sum += px;
      tmpl_energy += longint'(px) * px;
      tmpl_count++;
      return;
    end
    col = col_pos >= w ? w - 1 : col_pos;
    row = row_pos >= h ? h - 1 : row_pos;
    line_mem[(row % ncc_pkg::MAX_TEMPLATE_HEIGHT) * ncc_pkg::MAX_IMAGE_WIDTH + col] = px;
    if (col + 1 >= tw && row + 1 >= th) begin
      left = col + 1 - tw;
      top = row + 1 - th;
      st = tmpl_sum;
      num = 0;
      si = 0;
      si2 = 0;
      for (int unsigned r = 0; r < th; r++) begin
        base = ((top + r) % ncc_pkg::MAX_TEMPLATE_HEIGHT) * ncc_pkg::MAX_IMAGE_WIDTH;
        for (int unsigned c = 0; c < tw; c++) begin
          ti = r * tw + c;
          iv = line_mem[base + left + c];
          tv = ti < tmpl_count ? longint'(tmpl_mem[ti]) : 0;
          num += (longint'(n) * tv - st) * longint'(iv);
          si += iv;
          si2 += iv * iv;
        end
      end
      da = longint'(n) * si2 - si * si;
      db = longint'(n) * tmpl_energy - tmpl_sum * tmpl_sum;
      m.coef = 16'(q15_coef(num, da, db));
      m.col = left[ncc_pkg::COL_W-1:0];
      m.row = top[ncc_pkg::ROW_W-1:0];
      m.last = (col == w - 1 && row == h - 1);
      got = 1'b1;
    end
    if (col + 1 >= w) begin
      col_pos = 0;
      if (row + 1 >= h) begin
        row_pos = 0;
        clear_template();
      end else begin
        row_pos = row + 1;
      end
    end else begin
      col_pos = col + 1;
      row_pos = row;
    end
  endtask

  task automatic send_pixel(input logic opv, input logic [15:0] val,
                            input bit has_coef, input int coef);
    int gap;
    bit got;
    match_t m;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= opv;
    pixel_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_match(opv, val, got, m);
    if (got) begin
      if (has_coef) m.coef = 16'(coef);
      expected_matches.push_back(m);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input int unsigned iw, input int unsigned ih,
                              input int unsigned tw, input int unsigned th);
    int unsigned vals[4];
    vals = '{iw, ih, tw, th};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= ncc_pkg::CFG_IDX_W'(i);
      cfg_data <= ncc_pkg::CFG_W'(vals[i]);
      apply_register(i, vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic void add_cfg(int unsigned idx, int unsigned value);
    stim_table.push_back('{ROW_CFG, idx, value, 1'b0, 0});
  endfunction

  function automatic void add_pix(logic opv, int unsigned value, bit has_coef = 0, int coef = 0);
    stim_table.push_back('{ROW_PIX, opv, value, has_coef, coef});
  endfunction

  initial begin
    forever begin
      int gap;
      gap = (matches_seen == HOLD_AT) ? HOLD_CYCLES : draw_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      matches_seen++;
      if (expected_matches.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer coef=%0d col=%0d row=%0d last=%0b", $realtime,
                 coefficient, result_column, result_row, last_of_image);
      end else begin
        match_t e;
        e = expected_matches.pop_front();
        if (coefficient !== e.coef) begin
          errors++;
          $display("%0t: coefficient expected %0d actual %0d", $realtime, e.coef, coefficient);
        end
        if (result_column !== e.col) begin
          errors++;
          $display("%0t: result_column expected %0d actual %0d", $realtime, e.col,
                   result_column);
        end
        if (result_row !== e.row) begin
          errors++;
          $display("%0t: result_row expected %0d actual %0d", $realtime, e.row, result_row);
        end
        if (last_of_image !== e.last) begin
          errors++;
          $display("%0t: last_of_image expected %0b actual %0b", $realtime, e.last,
                   last_of_image);
        end
      end
    end
  end

  initial begin
    int unsigned iw, ih, tw, th, n, tcount, icount, rand_items;
    img_w_reg = 64;
    img_h_reg = 64;
    tmpl_w_reg = 8;
    tmpl_h_reg = 8;
    clear_template();
    col_pos = 0;
    row_pos = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_cfg(ncc_pkg::CFG_IMAGE_WIDTH, 2);
    add_cfg(ncc_pkg::CFG_IMAGE_HEIGHT, 1);
    add_cfg(ncc_pkg::CFG_TEMPLATE_WIDTH, 2);
    add_cfg(ncc_pkg::CFG_TEMPLATE_HEIGHT, 1);
    add_pix(OP_TEMPLATE, 0);
    add_pix(OP_TEMPLATE, 65535);
    add_pix(OP_IMAGE, 0);
    add_pix(OP_IMAGE, 65535, 1, 32767);
    add_pix(OP_TEMPLATE, 65535);
    add_pix(OP_TEMPLATE, 0);
    add_pix(OP_IMAGE, 0);
    add_pix(OP_IMAGE, 65535, 1, -32767);
    add_pix(OP_TEMPLATE, 5);
    add_pix(OP_TEMPLATE, 5);
    add_pix(OP_IMAGE, 1);
    add_pix(OP_IMAGE, 9, 1, 0);
    add_pix(OP_TEMPLATE, 1);
    add_pix(OP_TEMPLATE, 2);
    add_pix(OP_IMAGE, 7);
    add_pix(OP_IMAGE, 7, 1, 0);
    add_pix(OP_TEMPLATE, 3);
    add_pix(OP_IMAGE, 0);
    add_pix(OP_IMAGE, 65535, 1, -32767);
    add_pix(OP_TEMPLATE, 1);
    add_pix(OP_TEMPLATE, 2);
    add_pix(OP_IMAGE, 4);
    add_pix(OP_TEMPLATE, 10);
    add_pix(OP_TEMPLATE, 20);
    add_pix(OP_IMAGE, 1);
    add_pix(OP_IMAGE, 2, 1, 32767);

    for (int i = 0; i < stim_table.size(); i++) begin
      if (stim_table[i].kind == ROW_CFG) begin
        settle();
        cfg_we <= 1'b1;
        cfg_index <= ncc_pkg::CFG_IDX_W'(stim_table[i].sel);
        cfg_data <= ncc_pkg::CFG_W'(stim_table[i].value);
        apply_register(stim_table[i].sel, stim_table[i].value);
        @(posedge clk);
        cfg_we <= 1'b0;
      end else begin
        send_pixel(logic'(stim_table[i].sel), 16'(stim_table[i].value),
                   stim_table[i].has_coef, stim_table[i].coef);
      end
    end

    // widest template row, clamped sizes
    settle();
    write_config(2047, 0, 63, 63);
    for (int i = 0; i < ncc_pkg::MAX_TEMPLATE_WIDTH; i++)
      send_pixel(OP_TEMPLATE, draw_pixel(), 0, 0);
    for (int i = 0; i < 64; i++) send_pixel(OP_IMAGE, draw_pixel(), 0, 0);

    // tallest template, line store slots wrap
    settle();
    write_config(1, 40, 1, 32);
    for (int i = 0; i < ncc_pkg::MAX_TEMPLATE_HEIGHT; i++)
      send_pixel(OP_TEMPLATE, draw_pixel(), 0, 0);
    for (int i = 0; i < 40; i++) send_pixel(OP_IMAGE, draw_pixel(), 0, 0);

    // tallest image
    settle();
    write_config(1, 4095, 1, 1);
    send_pixel(OP_TEMPLATE, draw_pixel(), 0, 0);
    for (int i = 0; i < 20; i++) send_pixel(OP_IMAGE, draw_pixel(), 0, 0);

    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      settle();
      if ($urandom_range(0, 5) == 0) begin
        iw = $urandom_range(0, 4095);
        ih = $urandom_range(0, 4095);
        tw = $urandom_range(0, 63);
        th = $urandom_range(0, 63);
        write_config(iw, ih, tw, th);
        iw = iw & 32'h7FF;
        iw = iw < 1 ? 1 : (iw > ncc_pkg::MAX_IMAGE_WIDTH ? ncc_pkg::MAX_IMAGE_WIDTH : iw);
        ih = (ih < 1) ? 1 : ih;
        tw = tw < 1 ? 1 : (tw > ncc_pkg::MAX_TEMPLATE_WIDTH ? ncc_pkg::MAX_TEMPLATE_WIDTH : tw);
        if (tw > iw) tw = iw;
        th = th < 1 ? 1 :
             (th > ncc_pkg::MAX_TEMPLATE_HEIGHT ? ncc_pkg::MAX_TEMPLATE_HEIGHT : th);
        if (th > ih) th = ih;
      end else begin
        iw = $urandom_range(1, 12);
        ih = $urandom_range(1, 8);
        tw = $urandom_range(1, iw < 4 ? iw : 4);
        th = $urandom_range(1, ih < 4 ? ih : 4);
        write_config(iw, ih, tw, th);
      end
      n = tw * th;
      tcount = ($urandom_range(0, 6) == 0) ? $urandom_range(0, n + 2) : n;
      icount = iw * ih;
      if (icount > 60) icount = 60;
      if ($urandom_range(0, 4) == 0) icount += $urandom_range(1, 8);
      for (int i = 0; i < tcount; i++) begin
        send_pixel(OP_TEMPLATE, draw_pixel(), 0, 0);
        rand_items++;
      end
      for (int i = 0; i < icount; i++) begin
        send_pixel(($urandom_range(0, 19) == 0) ? OP_TEMPLATE : OP_IMAGE, draw_pixel(), 0, 0);
        rand_items++;
      end
    end

    settle();
    if (errors == 0 && expected_matches.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
